// ===== hw/rtl/text_line_indexer_unit_assert.svh =====
// Assertion macros for the text line indexer RTL, included by tli_back.
// Each macro expects signals named clk and arst_n in the enclosing module.
`ifndef TEXT_LINE_INDEXER_UNIT_ASSERT_SVH
`define TEXT_LINE_INDEXER_UNIT_ASSERT_SVH

// A condition that holds at every clock edge outside reset.
`define TLI_CHECK(label, cond, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (cond)) else $error(msg);

// A condition that holds at every edge at which the antecedent holds.
`define TLI_CHECK_IMP(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

`endif

// ===== hw/rtl/tli_pkg.sv =====
// Types, codes and helpers shared by the text line indexer modules.
// No dependencies.
package tli_pkg;

	localparam logic [7:0] CH_CR = 8'h0D;
	localparam logic [7:0] CH_LF = 8'h0A;

	localparam logic RK_LINE   = 1'b0;
	localparam logic RK_LOOKUP = 1'b1;

	localparam int QUEUE_DEPTH = 4;
	localparam int QPTR_W      = 2;

	typedef enum logic [1:0] {
		REQ_CLEAR  = 2'd0,
		REQ_BYTE   = 2'd1,
		REQ_EOT    = 2'd2,
		REQ_LOOKUP = 2'd3
	} req_t;

	typedef enum logic [1:0] {
		BC_OTHER = 2'd0,
		BC_CR    = 2'd1,
		BC_LF    = 2'd2
	} byte_class_t;

	typedef struct packed {
		req_t        req;
		byte_class_t bclass;
		logic [15:0] query;
	} cmd_t;

	function automatic logic [15:0] low16(input logic [31:0] v);
		return v[15:0];
	endfunction

	function automatic logic [9:0] low10(input logic [31:0] v);
		return v[9:0];
	endfunction

endpackage

// ===== hw/rtl/tli_front.sv =====
// Front end of the text line indexer: accepts request beats, classifies them
// and holds them in a short command queue. Depends on tli_pkg.
module tli_front import tli_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        req_valid,
	output logic        req_stall,
	input  logic [1:0]  req_type,
	input  logic [7:0]  data_byte,
	input  logic [15:0] query_position,
	output logic        cmd_valid,
	output cmd_t        cmd,
	input  logic        cmd_pop
);

	cmd_t              queue_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QPTR_W:0]   fill_q;
	logic              push;
	logic              pop;
	cmd_t              new_cmd;

	always_comb begin
		new_cmd.req = req_t'(req_type);
		new_cmd.query = query_position;
		if (data_byte == CH_CR) begin
			new_cmd.bclass = BC_CR;
		end else if (data_byte == CH_LF) begin
			new_cmd.bclass = BC_LF;
		end else begin
			new_cmd.bclass = BC_OTHER;
		end
	end

	assign req_stall = (fill_q == (QPTR_W+1)'(QUEUE_DEPTH));
	assign cmd_valid = (fill_q != '0);
	assign cmd = queue_q[rd_ptr_q];
	assign push = req_valid && !req_stall;
	assign pop = cmd_pop && cmd_valid;

	always_ff @(posedge clk) begin
		if (push) begin
			queue_q[wr_ptr_q] <= new_cmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			fill_q <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			case ({push, pop})
				2'b10: fill_q <= fill_q + 1'b1;
				2'b01: fill_q <= fill_q - 1'b1;
				default: fill_q <= fill_q;
			endcase
		end
	end

endmodule

// ===== hw/rtl/tli_back.sv =====
// Back end of the text line indexer: line splitting state, line start memory,
// binary search sequencer and the result register. Depends on tli_pkg and
// text_line_indexer_unit_assert.svh.
module tli_back import tli_pkg::*; #(
	parameter int MAX_LINES     = 1024,
	parameter int POSITION_BITS = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cmd_valid,
	input  cmd_t        cmd,
	output logic        cmd_pop,
	output logic        res_valid,
	input  logic        res_stall,
	output logic        result_kind,
	output logic [9:0]  line_number,
	output logic [15:0] line_begin,
	output logic [15:0] line_len,
	output logic [15:0] line_len_with_break,
	output logic        overflow_flag,
	output logic        last_of_run
);

	localparam int PW = POSITION_BITS;
	localparam int CW = $clog2(MAX_LINES + 1);
	localparam int AW = $clog2(MAX_LINES);
	localparam logic [PW-1:0] POS_MAX = {PW{1'b1}};
	localparam logic [CW-1:0] LINES_FULL = CW'(MAX_LINES);
	localparam logic [CW-1:0] LINE_LAST = CW'(MAX_LINES - 1);

	typedef enum logic [2:0] {
		S_IDLE,
		S_EOT2,
		S_LK_STEP,
		S_LK_CMP,
		S_LK_FIN
	} state_t;

	state_t         state_q;
	logic [CW-1:0]  count_q;
	logic [PW-1:0]  pos_q;
	logic [PW-1:0]  start_q;
	logic           pend_q;
	logic           ovf_q;
	logic [CW-1:0]  lo_q;
	logic [CW-1:0]  hi_q;
	logic [CW-1:0]  mid_q;
	logic [CW-1:0]  idx_q;
	logic [15:0]    query_q;
	logic [PW-1:0]  rd_q;
	logic [PW-1:0]  line_start_mem [MAX_LINES];

	logic           out_valid_q;
	logic           out_kind_q;
	logic [9:0]     out_num_q;
	logic [15:0]    out_begin_q;
	logic [15:0]    out_len_q;
	logic [15:0]    out_lenb_q;
	logic           out_ovf_q;
	logic           out_last_q;

	logic           slot_free;
	logic           full;
	logic           empty;
	logic [1:0]     adv;
	logic [1:0]     cl_w;
	logic           do_close;
	logic           start_p1;
	logic           pend_n;
	logic           emit;
	logic           rec_last;
	logic           act;
	logic           txt_go;
	logic           clr_go;
	logic           lk_go;
	state_t         txt_state_n;
	logic [PW:0]    sum;
	logic [PW:0]    sum_p1;
	logic           sat;
	logic [PW-1:0]  pos_n;
	logic [PW-1:0]  pos_p1;
	logic [PW-1:0]  start_n;
	logic [CW-1:0]  count_n;
	logic           ovf_n;
	logic [PW-1:0]  len;
	logic [CW-1:0]  num;
	logic           rec_ovf;
	logic [CW-1:0]  mid;
	logic [CW-1:0]  idx;
	logic           rd_en;
	logic [AW-1:0]  rd_addr;
	logic           mem_we;
	logic           lk_hit;
	logic           out_load;
	logic           o_kind;
	logic [9:0]     o_num;
	logic [15:0]    o_begin;
	logic [15:0]    o_len;
	logic [15:0]    o_lenb;
	logic           o_ovf;
	logic           o_last;

	assign slot_free = !out_valid_q || !res_stall;
	assign full = (count_q == LINES_FULL);
	assign empty = (count_q == '0);

	always_comb begin
		adv = 2'd0;
		cl_w = 2'd0;
		do_close = 1'b0;
		start_p1 = 1'b0;
		pend_n = pend_q;
		rec_last = 1'b1;
		txt_state_n = S_IDLE;
		if (state_q == S_EOT2) begin
			do_close = 1'b1;
		end else begin
			case (cmd.req)
				REQ_BYTE: begin
					if (pend_q) begin
						do_close = 1'b1;
						case (cmd.bclass)
							BC_LF: begin
								cl_w = 2'd2;
								adv = 2'd2;
								pend_n = 1'b0;
							end
							BC_CR: begin
								cl_w = 2'd1;
								adv = 2'd1;
								pend_n = 1'b1;
							end
							default: begin
								cl_w = 2'd1;
								adv = 2'd2;
								start_p1 = 1'b1;
								pend_n = 1'b0;
							end
						endcase
					end else begin
						case (cmd.bclass)
							BC_CR: pend_n = 1'b1;
							BC_LF: begin
								do_close = 1'b1;
								cl_w = 2'd1;
								adv = 2'd1;
							end
							default: adv = 2'd1;
						endcase
					end
				end
				REQ_EOT: begin
					do_close = 1'b1;
					pend_n = 1'b0;
					if (pend_q) begin
						cl_w = 2'd1;
						adv = 2'd1;
						rec_last = 1'b0;
						txt_state_n = S_EOT2;
					end
				end
				default: begin
				end
			endcase
		end
	end

	assign emit = do_close;
	assign act = !emit || slot_free;
	assign txt_go = act && ((state_q == S_EOT2) || (state_q == S_IDLE && cmd_valid &&
		(cmd.req == REQ_BYTE || cmd.req == REQ_EOT)));
	assign clr_go = (state_q == S_IDLE) && cmd_valid && (cmd.req == REQ_CLEAR);
	assign lk_go = (state_q == S_IDLE) && cmd_valid && (cmd.req == REQ_LOOKUP);
	assign cmd_pop = clr_go || lk_go || (txt_go && state_q == S_IDLE);

	assign sum = {1'b0, pos_q} + (PW+1)'(adv);
	assign sat = (sum > {1'b0, POS_MAX});
	assign pos_n = sat ? POS_MAX : sum[PW-1:0];
	assign sum_p1 = {1'b0, pos_q} + (PW+1)'(1);
	assign pos_p1 = (sum_p1 > {1'b0, POS_MAX}) ? POS_MAX : sum_p1[PW-1:0];
	assign start_n = start_p1 ? pos_p1 : pos_n;
	assign count_n = (do_close && !full) ? count_q + 1'b1 : count_q;
	assign ovf_n = ovf_q || (do_close && full) || sat;
	assign len = pos_q - start_q;
	assign num = full ? LINE_LAST : count_q;
	assign rec_ovf = rec_last ? ovf_n : (ovf_n || count_n == LINES_FULL);
	assign mem_we = txt_go && do_close && !full;

	assign mid = lo_q + ((hi_q - lo_q) >> 1);
	assign idx = (lo_q != '0) ? lo_q - 1'b1 : '0;
	assign rd_en = (state_q == S_LK_STEP);
	assign rd_addr = (lo_q < hi_q) ? mid[AW-1:0] : idx[AW-1:0];
	assign lk_hit = (32'(rd_q) <= 32'(query_q));

	always_comb begin
		out_load = 1'b0;
		o_kind = RK_LINE;
		o_num = low10(32'(num));
		o_begin = low16(32'(start_q));
		o_len = low16(32'(len));
		o_lenb = low16(32'(len) + 32'(cl_w));
		o_ovf = rec_ovf;
		o_last = rec_last;
		if (state_q == S_LK_FIN) begin
			out_load = slot_free;
			o_kind = RK_LOOKUP;
			o_num = low10(32'(idx_q));
			o_begin = empty ? 16'd0 : low16(32'(rd_q));
			o_len = 16'd0;
			o_lenb = 16'd0;
			o_ovf = empty;
			o_last = 1'b1;
		end else if (txt_go && emit) begin
			out_load = 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			line_start_mem[count_q[AW-1:0]] <= start_q;
		end
		if (rd_en) begin
			rd_q <= line_start_mem[rd_addr];
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			out_kind_q <= o_kind;
			out_num_q <= o_num;
			out_begin_q <= o_begin;
			out_len_q <= o_len;
			out_lenb_q <= o_lenb;
			out_ovf_q <= o_ovf;
			out_last_q <= o_last;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			count_q <= '0;
			pos_q <= '0;
			start_q <= '0;
			pend_q <= 1'b0;
			ovf_q <= 1'b0;
			lo_q <= '0;
			hi_q <= '0;
			mid_q <= '0;
			idx_q <= '0;
			query_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (!res_stall) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (clr_go) begin
						count_q <= '0;
						pos_q <= '0;
						start_q <= '0;
						pend_q <= 1'b0;
						ovf_q <= 1'b0;
					end else if (lk_go) begin
						query_q <= cmd.query;
						lo_q <= '0;
						hi_q <= count_q;
						state_q <= S_LK_STEP;
					end else if (txt_go) begin
						count_q <= count_n;
						pos_q <= pos_n;
						pend_q <= pend_n;
						ovf_q <= ovf_n;
						if (do_close) begin
							start_q <= start_n;
						end
						state_q <= txt_state_n;
					end
				end
				S_EOT2: begin
					if (txt_go) begin
						count_q <= count_n;
						ovf_q <= ovf_n;
						start_q <= start_n;
						state_q <= S_IDLE;
					end
				end
				S_LK_STEP: begin
					if (lo_q < hi_q) begin
						mid_q <= mid;
						state_q <= S_LK_CMP;
					end else begin
						idx_q <= idx;
						state_q <= S_LK_FIN;
					end
				end
				S_LK_CMP: begin
					if (lk_hit) begin
						lo_q <= mid_q + 1'b1;
					end else begin
						hi_q <= mid_q;
					end
					state_q <= S_LK_STEP;
				end
				S_LK_FIN: begin
					if (slot_free) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign res_valid = out_valid_q;
	assign result_kind = out_kind_q;
	assign line_number = out_num_q;
	assign line_begin = out_begin_q;
	assign line_len = out_len_q;
	assign line_len_with_break = out_lenb_q;
	assign overflow_flag = out_ovf_q;
	assign last_of_run = out_last_q;

	`include "text_line_indexer_unit_assert.svh"

	`TLI_CHECK(a_count_bound, count_q <= LINES_FULL, "line count beyond table size")
	`TLI_CHECK(a_start_le_pos, start_q <= pos_q, "open line starts past position")
	`TLI_CHECK_IMP(a_search_order, state_q == S_LK_STEP || state_q == S_LK_CMP, lo_q <= hi_q, "search bounds crossed")
	`TLI_CHECK_IMP(a_eot_first, state_q == S_EOT2 && $past(state_q) == S_IDLE, out_valid_q && !out_last_q && out_kind_q == RK_LINE, "first end-of-text record missing")

endmodule

// ===== hw/rtl/text_line_indexer_unit.sv =====
// Text line indexer: splits a byte stream into lines, records line starts
// and maps positions back to line numbers. Depends on tli_pkg, tli_front
// and tli_back.
//
// Requests enter on req_valid/req_stall; a beat is taken when req_valid is
// high and req_stall is low. Results leave on res_valid/res_stall in the same
// way, one record per beat, with last_of_run marking the final record of a
// request. A four-entry command queue separates intake from execution, so
// requests keep flowing while a result waits in the output register.
// Text bytes, clears and end-of-text requests run at one request per cycle
// while the receiver does not stall; an end of text after a carriage return
// produces two records, the second from S_EOT2. A lookup runs a binary
// search over the line start memory, one read per S_LK_STEP/S_LK_CMP step,
// then S_LK_FIN. Text results pass through the command queue and then the
// result register. Reset clears the queue, counters and flags; the line start
// memory holds no reset value and is read below the stored line count, save
// at address zero for an empty table, whose result is masked. A receiver
// stall holds the result register; req_stall rises once the queue is full.
module text_line_indexer_unit import tli_pkg::*; #(
	parameter int MAX_LINES     = 1024,
	parameter int POSITION_BITS = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        req_valid,
	output logic        req_stall,
	input  logic [1:0]  req_type,
	input  logic [7:0]  data_byte,
	input  logic [15:0] query_position,
	output logic        res_valid,
	input  logic        res_stall,
	output logic        result_kind,
	output logic [9:0]  line_number,
	output logic [15:0] line_begin,
	output logic [15:0] line_len,
	output logic [15:0] line_len_with_break,
	output logic        overflow_flag,
	output logic        last_of_run
);

	logic cmd_valid;
	cmd_t cmd;
	logic cmd_pop;

	tli_front u_front (
		.clk            (clk),
		.arst_n         (arst_n),
		.req_valid      (req_valid),
		.req_stall      (req_stall),
		.req_type       (req_type),
		.data_byte      (data_byte),
		.query_position (query_position),
		.cmd_valid      (cmd_valid),
		.cmd            (cmd),
		.cmd_pop        (cmd_pop)
	);

	tli_back #(
		.MAX_LINES     (MAX_LINES),
		.POSITION_BITS (POSITION_BITS)
	) u_back (
		.clk                 (clk),
		.arst_n              (arst_n),
		.cmd_valid           (cmd_valid),
		.cmd                 (cmd),
		.cmd_pop             (cmd_pop),
		.res_valid           (res_valid),
		.res_stall           (res_stall),
		.result_kind         (result_kind),
		.line_number         (line_number),
		.line_begin          (line_begin),
		.line_len            (line_len),
		.line_len_with_break (line_len_with_break),
		.overflow_flag       (overflow_flag),
		.last_of_run         (last_of_run)
	);

endmodule
